// ----- rtl/core/kau_pkg.sv -----
`timescale 1ns / 1ps

package kau_pkg;

    localparam int ANGLE_W    = 32;
    localparam int VAR_W      = 32;
    localparam int STEP_W     = 24;
    localparam int FRAC_W     = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Grown widths of the intermediates
    localparam int PROD_W   = STEP_W + ANGLE_W + 1;   // signed dt * rate
    localparam int PANGLE_W = ANGLE_W + 3;            // predicted angle, signed
    localparam int PVAR_W   = VAR_W + 1;              // predicted variance
    localparam int DEN_W    = VAR_W + 2;              // pred_var + meas variance
    localparam int GAIN_W   = FRAC_W + 1;             // gain, Q1.24, at most one

    localparam int IN_DATA_W  = 4 * ANGLE_W;
    localparam int OUT_DATA_W = 2 * ANGLE_W;

    localparam logic [STEP_W-1:0] TIME_STEP_RST  = 24'd67109;
    localparam logic [VAR_W-1:0]  PROC_NOISE_RST = 32'd4295;
    localparam logic [VAR_W-1:0]  MEAS_VAR_RST   = 32'd150994944;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TIME_STEP  = 2'd0,
        CFG_PROC_NOISE = 2'd1,
        CFG_MEAS_VAR   = 2'd2
    } t_cfg_addr;

    typedef struct packed {
        logic [STEP_W-1:0] time_step;
        logic [VAR_W-1:0]  proc_noise;
        logic [VAR_W-1:0]  meas_var;
    } t_cfg;

    // Payload that rides alongside the divider
    typedef struct packed {
        logic [PANGLE_W-1:0] pred_angle;
        logic [ANGLE_W-1:0]  meas;
        logic [PVAR_W-1:0]   pred_var;
    } t_side;

endpackage

// ----- rtl/core/kau_front.sv -----
`timescale 1ns / 1ps

module kau_front
    import kau_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [ANGLE_W-1:0] i_prior_angle,
    input  logic [VAR_W-1:0]          i_prior_variance,
    input  logic signed [ANGLE_W-1:0] i_angular_rate,
    input  logic signed [ANGLE_W-1:0] i_measured_angle,
    input  t_cfg                      i_cfg,
    output logic                      o_valid,
    output t_side                     o_side,
    output logic [DEN_W-1:0]          o_denom
);

    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);

    // stage 1: dt * rate, variance prediction
    logic                      r_v1;
    logic signed [PROD_W-1:0]  r_prod;
    logic [ANGLE_W-1:0]        r_angle1;
    logic [ANGLE_W-1:0]        r_meas1;
    logic [PVAR_W-1:0]         r_pvar1;
    logic signed [PROD_W-1:0]  n_prod;
    logic [PVAR_W-1:0]         n_pvar;

    // stage 2: round and add to the angle, form the divisor
    logic                      r_v2;
    t_side                     r_side2;
    logic [DEN_W-1:0]          r_den2;
    logic signed [PROD_W:0]    n_rsum;
    logic signed [PROD_W:0]    n_delta;
    t_side                     n_side;
    logic [DEN_W-1:0]          n_den;

    always_comb begin
        n_prod = $signed({1'b0, i_cfg.time_step}) * i_angular_rate;
        n_pvar = {1'b0, i_prior_variance} + {1'b0, i_cfg.proc_noise};
    end

    always_comb begin
        n_rsum              = {r_prod[PROD_W-1], r_prod} + $signed(HALF);
        n_delta             = n_rsum >>> FRAC_W;
        n_side.pred_angle   = {{(PANGLE_W - ANGLE_W){r_angle1[ANGLE_W-1]}}, r_angle1}
                              + n_delta[PANGLE_W-1:0];
        n_side.meas         = r_meas1;
        n_side.pred_var     = r_pvar1;
        n_den               = {1'b0, r_pvar1} + {2'b0, i_cfg.meas_var};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_angle1 <= i_prior_angle;
            r_meas1  <= i_measured_angle;
            r_pvar1  <= n_pvar;
            r_side2  <= n_side;
            r_den2   <= n_den;
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_side2;
    assign o_denom = r_den2;

endmodule

// ----- rtl/core/kau_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, most significant bit first.
// pred_var <= denom, so the quotient never exceeds one in Q1.24.
// A zero divisor yields a zero quotient.
module kau_div
    import kau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [DEN_W-1:0]  i_denom,
    output logic              o_valid,
    output t_side             o_side,
    output logic [GAIN_W-1:0] o_gain
);

    localparam int STAGES = GAIN_W;

    logic [STAGES-1:0] r_vld;
    logic [DEN_W-1:0]  r_rem  [STAGES];
    logic [DEN_W-1:0]  r_den  [STAGES];
    logic [GAIN_W-1:0] r_q    [STAGES];
    t_side             r_side [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [DEN_W:0]    n_sh;
        logic [DEN_W+1:0]  n_trial;
        logic              n_ge;
        logic [DEN_W-1:0]  n_den;
        logic [GAIN_W-1:0] n_q_in;
        t_side             n_side_in;
        logic              n_vld_in;

        if (k == 0) begin : g_first
            always_comb begin
                n_sh      = {2'b0, i_side.pred_var};
                n_den     = i_denom;
                n_q_in    = '0;
                n_side_in = i_side;
                n_vld_in  = i_valid;
            end
        end else begin : g_next
            always_comb begin
                n_sh      = {r_rem[k-1], 1'b0};
                n_den     = r_den[k-1];
                n_q_in    = r_q[k-1];
                n_side_in = r_side[k-1];
                n_vld_in  = r_vld[k-1];
            end
        end

        always_comb begin
            n_trial = {1'b0, n_sh} - {2'b0, n_den};
            n_ge    = !n_trial[DEN_W+1] && (n_den != '0);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? n_trial[DEN_W-1:0] : n_sh[DEN_W-1:0];
                r_den[k]  <= n_den;
                r_q[k]    <= {n_q_in[GAIN_W-2:0], n_ge};
                r_side[k] <= n_side_in;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_gain  = r_q[STAGES-1];

endmodule

// ----- rtl/core/kau_back.sv -----
`timescale 1ns / 1ps

module kau_back
    import kau_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  t_side                     i_side,
    input  logic [GAIN_W-1:0]         i_gain,
    output logic                      o_valid,
    output logic signed [ANGLE_W-1:0] o_new_angle,
    output logic [VAR_W-1:0]          o_new_variance
);

    localparam int INNOV_W = PANGLE_W + 1;
    localparam int ILO_W   = 18;
    localparam int IHI_W   = INNOV_W - ILO_W;
    localparam int VLO_W   = 17;
    localparam int VHI_W   = PVAR_W - VLO_W;
    localparam int PAL_W   = GAIN_W + ILO_W;
    localparam int PAH_W   = GAIN_W + 1 + IHI_W;
    localparam int PVL_W   = GAIN_W + VLO_W;
    localparam int PVH_W   = GAIN_W + VHI_W;
    localparam int FA_W    = PAH_W + ILO_W + 1;
    localparam int FV_W    = GAIN_W + PVAR_W + 1;
    localparam int SUM_W   = ANGLE_W + 8;

    localparam logic [GAIN_W-1:0] ONE    = GAIN_W'(1) << FRAC_W;
    localparam logic [FA_W-1:0]   HALF_A = FA_W'(1) << (FRAC_W - 1);
    localparam logic [FV_W-1:0]   HALF_V = FV_W'(1) << (FRAC_W - 1);

    localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'({1'b0, {(ANGLE_W - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] S_MIN = -S_MAX - SUM_W'(1);

    // stage A: innovation and 1 - gain
    logic                       r_va;
    logic signed [INNOV_W-1:0]  r_innov;
    logic [GAIN_W-1:0]          r_gain_a;
    logic [GAIN_W-1:0]          r_omg;
    logic [PANGLE_W-1:0]        r_pang_a;
    logic [PVAR_W-1:0]          r_pvar_a;

    // stage B: partial products
    logic                       r_vb;
    logic [PAL_W-1:0]           r_pa_lo;
    logic signed [PAH_W-1:0]    r_pa_hi;
    logic [PVL_W-1:0]           r_pv_lo;
    logic [PVH_W-1:0]           r_pv_hi;
    logic [PANGLE_W-1:0]        r_pang_b;

    // stage C: combine and add the rounding half
    logic                       r_vc;
    logic signed [FA_W-1:0]     r_fa;
    logic [FV_W-1:0]            r_fv;
    logic [PANGLE_W-1:0]        r_pang_c;

    // stage D: output register
    logic                       r_vd;
    logic [ANGLE_W-1:0]         r_angle_d;
    logic [VAR_W-1:0]           r_var_d;

    logic signed [INNOV_W-1:0]  n_innov;
    logic [PAL_W-1:0]           n_pa_lo;
    logic signed [PAH_W-1:0]    n_pa_hi;
    logic [PVL_W-1:0]           n_pv_lo;
    logic [PVH_W-1:0]           n_pv_hi;
    logic [FA_W-1:0]            n_fa;
    logic [FV_W-1:0]            n_fv;
    logic signed [FA_W-1:0]     n_adj;
    logic signed [SUM_W-1:0]    n_sum;
    logic [FV_W-FRAC_W-1:0]     n_vq;
    logic [ANGLE_W-1:0]         n_angle;
    logic [VAR_W-1:0]           n_var;

    always_comb begin
        n_innov = $signed({{(INNOV_W - ANGLE_W){i_side.meas[ANGLE_W-1]}}, i_side.meas})
                  - $signed({i_side.pred_angle[PANGLE_W-1], i_side.pred_angle});
    end

    always_comb begin
        n_pa_lo = r_gain_a * r_innov[ILO_W-1:0];
        n_pa_hi = $signed({1'b0, r_gain_a}) * $signed(r_innov[INNOV_W-1:ILO_W]);
        n_pv_lo = r_omg * r_pvar_a[VLO_W-1:0];
        n_pv_hi = r_omg * r_pvar_a[PVAR_W-1:VLO_W];
    end

    always_comb begin
        n_fa = {r_pa_hi[PAH_W-1], r_pa_hi, {ILO_W{1'b0}}}
               + {{(FA_W - PAL_W){1'b0}}, r_pa_lo} + HALF_A;
        n_fv = {1'b0, r_pv_hi, {VLO_W{1'b0}}}
               + {{(FV_W - PVL_W){1'b0}}, r_pv_lo} + HALF_V;
    end

    always_comb begin
        n_adj = r_fa >>> FRAC_W;
        n_sum = $signed({{(SUM_W - PANGLE_W){r_pang_c[PANGLE_W-1]}}, r_pang_c})
                + $signed(n_adj[SUM_W-1:0]);
        if (n_sum > S_MAX) begin
            n_angle = S_MAX[ANGLE_W-1:0];
        end else if (n_sum < S_MIN) begin
            n_angle = S_MIN[ANGLE_W-1:0];
        end else begin
            n_angle = n_sum[ANGLE_W-1:0];
        end
        n_vq  = r_fv[FV_W-1:FRAC_W];
        // clip to all ones when the rounded variance overflows 32 bits
        n_var = (|n_vq[FV_W-FRAC_W-1:VAR_W]) ? '1 : n_vq[VAR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_innov   <= n_innov;
            r_gain_a  <= i_gain;
            r_omg     <= ONE - i_gain;
            r_pang_a  <= i_side.pred_angle;
            r_pvar_a  <= i_side.pred_var;
            r_pa_lo   <= n_pa_lo;
            r_pa_hi   <= n_pa_hi;
            r_pv_lo   <= n_pv_lo;
            r_pv_hi   <= n_pv_hi;
            r_pang_b  <= r_pang_a;
            r_fa      <= n_fa;
            r_fv      <= n_fv;
            r_pang_c  <= r_pang_b;
            r_angle_d <= n_angle;
            r_var_d   <= n_var;
        end
    end

    assign o_valid        = r_vd;
    assign o_new_angle    = r_angle_d;
    assign o_new_variance = r_var_d;

endmodule

// ----- rtl/core/kalman_angle_update_1d.sv -----
`timescale 1ns / 1ps
// From an input transfer to its result on the output register, an item passes through
// 2 prediction stages, 25 divider stages at one gain bit each, and 4 correction stages.
// Throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or its result is taken, so s_axis_tready follows m_axis_tready.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.

module kalman_angle_update_1d
    import kau_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // prior_angle[31:0], prior_variance[63:32], angular_rate[95:64],
    // measured_angle[127:96]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // new_angle[31:0], new_variance[63:32]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg                      r_cfg;
    logic                      w_en;
    logic                      w_f_valid;
    t_side                     w_f_side;
    logic [DEN_W-1:0]          w_f_denom;
    logic                      w_d_valid;
    t_side                     w_d_side;
    logic [GAIN_W-1:0]         w_d_gain;
    logic signed [ANGLE_W-1:0] w_new_angle;
    logic [VAR_W-1:0]          w_new_variance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step  <= TIME_STEP_RST;
            r_cfg.proc_noise <= PROC_NOISE_RST;
            r_cfg.meas_var   <= MEAS_VAR_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_TIME_STEP:  r_cfg.time_step  <= i_cfg_wdata[STEP_W-1:0];
                CFG_PROC_NOISE: r_cfg.proc_noise <= i_cfg_wdata[VAR_W-1:0];
                CFG_MEAS_VAR:   r_cfg.meas_var   <= i_cfg_wdata[VAR_W-1:0];
                default: ;
            endcase
        end
    end

    // advance everything unless a result sits unclaimed at the output
    assign w_en          = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = w_en;

    kau_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (s_axis_tvalid),
        .i_prior_angle    (s_axis_tdata[ANGLE_W-1:0]),
        .i_prior_variance (s_axis_tdata[2*ANGLE_W-1:ANGLE_W]),
        .i_angular_rate   (s_axis_tdata[3*ANGLE_W-1:2*ANGLE_W]),
        .i_measured_angle (s_axis_tdata[4*ANGLE_W-1:3*ANGLE_W]),
        .i_cfg            (r_cfg),
        .o_valid          (w_f_valid),
        .o_side           (w_f_side),
        .o_denom          (w_f_denom)
    );

    kau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_side  (w_f_side),
        .i_denom (w_f_denom),
        .o_valid (w_d_valid),
        .o_side  (w_d_side),
        .o_gain  (w_d_gain)
    );

    kau_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_d_valid),
        .i_side         (w_d_side),
        .i_gain         (w_d_gain),
        .o_valid        (m_axis_tvalid),
        .o_new_angle    (w_new_angle),
        .o_new_variance (w_new_variance)
    );

    assign m_axis_tdata = {w_new_variance, w_new_angle};

endmodule

// ----- rtl/core/kau_checker.sv -----
`timescale 1ns / 1ps

module kau_checker
    import kau_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output result changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // input side is blocked exactly when a result waits unclaimed
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (m_axis_tready || !m_axis_tvalid))
        else $error("input ready does not follow output stall");

endmodule

bind kalman_angle_update_1d kau_checker u_kau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_kalman_angle_update_1d.sv -----
`timescale 1ns / 1ps

module tb_kalman_angle_update_1d;
    import kau_pkg::*;

    localparam int HALF_PERIOD     = 1;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 40;    // covers the pipeline plus margin
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 236;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;   // no register behind it

    localparam longint      RND_HALF  = 64'sd8388608;
    localparam logic [63:0] GAIN_ONE  = 64'd1 << FRAC_W;
    localparam logic [63:0] GAIN_HALF = 64'd1 << (FRAC_W - 1);
    localparam longint      ANGLE_MAX = 64'sh7FFF_FFFF;
    localparam longint      ANGLE_MIN = -64'sh8000_0000;

    // Declared high field first so that prior_angle lands in the low bits
    typedef struct packed {
        logic [ANGLE_W-1:0] measured_angle;
        logic [ANGLE_W-1:0] angular_rate;
        logic [VAR_W-1:0]   prior_variance;
        logic [ANGLE_W-1:0] prior_angle;
    } t_sample;

    typedef struct packed {
        logic [VAR_W-1:0]   new_variance;
        logic [ANGLE_W-1:0] new_angle;
    } t_update;

    typedef enum int {
        CS_RESET,
        CS_ZERO,
        CS_UNIT_STEP,
        CS_FULL,
        CS_EXACT,
        CS_RANDOM
    } t_setting;

    typedef struct {
        t_setting    setting;
        logic [31:0] prior_angle;
        logic [31:0] prior_variance;
        logic [31:0] angular_rate;
        logic [31:0] measured_angle;
        bit          typed;
        logic [31:0] want_angle;
        logic [31:0] want_variance;
    } t_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    t_cfg    cfg_shadow;
    t_update pending_updates [$];
    int      error_count    = 0;
    int      quiet_cycles   = 0;
    int      src_gap_pct    = 0;
    int      sink_stall_pct = 0;

    t_row directed_rows [23] = '{
        // reset settings
        '{CS_RESET, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'd4295},
        '{CS_RESET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{CS_RESET, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000,
          1'b0, 32'h0, 32'h0},
        '{CS_RESET, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
          1'b0, 32'h0, 32'h0},
        '{CS_RESET, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{CS_RESET, 32'h0001_0000, 32'h0100_0000, 32'h0064_0000, 32'h0002_0000,
          1'b0, 32'h0, 32'h0},
        '{CS_RESET, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
          1'b0, 32'h0, 32'h0},
        // all registers zero: a zero denominator keeps the prior angle, else gain one takes the measurement
        '{CS_ZERO, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b1, 32'h8000_0000, 32'h0},
        '{CS_ZERO, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000,
          1'b1, 32'h7FFF_FFFF, 32'h0},
        '{CS_ZERO, 32'h1234_5678, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000,
          1'b1, 32'h8000_0000, 32'h0},
        '{CS_ZERO, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b1, 32'h7FFF_FFFF, 32'h0},
        // unit time step: rounding ties and angle saturation, gain zero
        '{CS_UNIT_STEP, 32'h0000_0100, 32'h0, 32'h0080_0000, 32'h0,
          1'b1, 32'h0000_0101, 32'h0},
        '{CS_UNIT_STEP, 32'h0000_0100, 32'h0, 32'hFF80_0000, 32'h0,
          1'b1, 32'h0000_0100, 32'h0},
        '{CS_UNIT_STEP, 32'h0000_0100, 32'h0, 32'h007F_FFFF, 32'h0,
          1'b1, 32'h0000_0100, 32'h0},
        '{CS_UNIT_STEP, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0,
          1'b1, 32'h7FFF_FFFF, 32'h0},
        '{CS_UNIT_STEP, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0,
          1'b1, 32'h8000_0000, 32'h0},
        // every register at its maximum
        '{CS_FULL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{CS_FULL, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          1'b0, 32'h0, 32'h0},
        '{CS_FULL, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          1'b0, 32'h0, 32'h0},
        '{CS_FULL, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          1'b0, 32'h0, 32'h0},
        // zero measurement variance: the angle snaps to the measurement
        '{CS_EXACT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          1'b1, 32'h8000_0000, 32'h0},
        '{CS_EXACT, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b1, 32'h7FFF_FFFF, 32'h0},
        '{CS_EXACT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678,
          1'b1, 32'h1234_5678, 32'h0}
    };

    t_setting phase_plan [7] = '{
        CS_RESET, CS_FULL, CS_RANDOM, CS_UNIT_STEP, CS_RANDOM, CS_EXACT, CS_RANDOM
    };

    kalman_angle_update_1d dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic t_update kalman_step(t_sample s);
        longint      angle_pred;
        longint      innov;
        longint      angle_new;
        logic [63:0] var_pred;
        logic [63:0] denom;
        logic [63:0] gain;
        logic [63:0] var_new;
        t_update     r;
        angle_pred = longint'(signed'(s.prior_angle))
                   + ((longint'(cfg_shadow.time_step) * longint'(signed'(s.angular_rate))
                       + RND_HALF) >>> FRAC_W);
        var_pred   = 64'(s.prior_variance) + 64'(cfg_shadow.proc_noise);
        denom      = var_pred + 64'(cfg_shadow.meas_var);
        gain       = (denom == 64'd0) ? 64'd0 : (var_pred << FRAC_W) / denom;
        innov      = longint'(signed'(s.measured_angle)) - angle_pred;
        angle_new  = angle_pred + ((longint'(gain) * innov + RND_HALF) >>> FRAC_W);
        var_new    = ((GAIN_ONE - gain) * var_pred + GAIN_HALF) >> FRAC_W;

        if (angle_new > ANGLE_MAX) begin
            r.new_angle = 32'h7FFF_FFFF;
        end else if (angle_new < ANGLE_MIN) begin
            r.new_angle = 32'h8000_0000;
        end else begin
            r.new_angle = angle_new[31:0];
        end
        r.new_variance = (var_new > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : var_new[31:0];
        return r;
    endfunction

    function automatic t_cfg settings_for(t_setting sel);
        t_cfg c;
        case (sel)
            CS_RESET: begin
                c.time_step  = TIME_STEP_RST;
                c.proc_noise = PROC_NOISE_RST;
                c.meas_var   = MEAS_VAR_RST;
            end
            CS_ZERO: begin
                c.time_step  = '0;
                c.proc_noise = '0;
                c.meas_var   = '0;
            end
            CS_UNIT_STEP: begin
                c.time_step  = 24'd1;
                c.proc_noise = '0;
                c.meas_var   = '1;
            end
            CS_FULL: begin
                c.time_step  = '1;
                c.proc_noise = '1;
                c.meas_var   = '1;
            end
            CS_EXACT: begin
                c.time_step  = '1;
                c.proc_noise = '1;
                c.meas_var   = '0;
            end
            default: begin
                c.time_step  = 24'($urandom >> $urandom_range(8, 31));
                c.proc_noise = $urandom >> $urandom_range(31);
                c.meas_var   = $urandom >> $urandom_range(31);
            end
        endcase
        return c;
    endfunction

    // Extremes, plausible magnitudes, or anything at all
    function automatic logic [31:0] pick_field(bit is_variance);
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'h7FFF_FFFF;
                    3:       return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3, 4: begin
                if (is_variance) begin
                    return $urandom_range(0, 32'h1000_0000);
                end
                return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            end
            default: begin
                if (is_variance) begin
                    return $urandom >> $urandom_range(31);
                end
                return $urandom;
            end
        endcase
    endfunction

    task automatic push_sample(t_sample s, t_update want);
        while ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_updates.push_back(want);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_updates.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_TIME_STEP;
        i_cfg_wdata <= {8'($urandom), c.time_step};   // upper byte must be dropped
        @(posedge i_clk);
        i_cfg_addr  <= CFG_PROC_NOISE;
        i_cfg_wdata <= c.proc_noise;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_MEAS_VAR;
        i_cfg_wdata <= c.meas_var;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SPARE;
        i_cfg_wdata <= $urandom;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_shadow = c;
    endtask

    always @(posedge i_clk) begin
        t_update got;
        t_update want;
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (i_rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected transfer, angle %h variance %h",
                         $time, got.new_angle, got.new_variance);
                error_count++;
            end else begin
                want = pending_updates.pop_front();
                if (got.new_angle !== want.new_angle) begin
                    $display("%0t: new_angle expected %h actual %h",
                             $time, want.new_angle, got.new_angle);
                    error_count++;
                end
                if (got.new_variance !== want.new_variance) begin
                    $display("%0t: new_variance expected %h actual %h",
                             $time, want.new_variance, got.new_variance);
                    error_count++;
                end
            end
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_sample  s;
        t_update  want;
        t_setting now_setting;
        cfg_shadow     = settings_for(CS_RESET);
        src_gap_pct    = 28;
        sink_stall_pct = 51;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        now_setting = CS_RESET;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].setting != now_setting) begin
                settle();
                now_setting = directed_rows[i].setting;
                load_settings(settings_for(now_setting));
            end
            s.prior_angle    = directed_rows[i].prior_angle;
            s.prior_variance = directed_rows[i].prior_variance;
            s.angular_rate   = directed_rows[i].angular_rate;
            s.measured_angle = directed_rows[i].measured_angle;
            if (directed_rows[i].typed) begin
                want.new_angle    = directed_rows[i].want_angle;
                want.new_variance = directed_rows[i].want_variance;
            end else begin
                want = kalman_step(s);
            end
            push_sample(s, want);
        end

        foreach (phase_plan[p]) begin
            settle();
            load_settings(settings_for(phase_plan[p]));
            case (p * 3 / 7)
                0: begin
                    src_gap_pct    = 28;
                    sink_stall_pct = 51;
                end
                1: begin
                    src_gap_pct    = 51;
                    sink_stall_pct = 28;
                end
                default: begin
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                // now and then let the pipeline run dry
                if ($urandom_range(99) == 0) begin
                    hold_until_drained();
                end
                s.prior_angle    = pick_field(1'b0);
                s.prior_variance = pick_field(1'b1);
                s.angular_rate   = pick_field(1'b0);
                s.measured_angle = pick_field(1'b0);
                push_sample(s, kalman_step(s));
            end
        end

        settle();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/kau_pkg.sv
rtl/core/kau_front.sv
rtl/core/kau_div.sv
rtl/core/kau_back.sv
rtl/core/kalman_angle_update_1d.sv
rtl/core/kau_checker.sv
tb/tb_kalman_angle_update_1d.sv
